@@ src/assert_macros.svh @@
// assertion macros used by the block's rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain implication checked on every edge outside reset
`define ADNZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ADNZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/adnz_pkg.sv @@
// types, constants and angle tables of the stick dead zone block
package adnz_pkg;

  localparam int DIV_W     = 49;
  localparam int DVS_W     = 32;
  localparam int DIV_CNT_W = 6;
  localparam int SQ_W      = 50;
  localparam int RT_W      = 25;
  localparam int SQ_CNT_W  = 5;

  localparam logic [16:0] DEAD_S      = 17'd9216;
  localparam logic [15:0] SCALE_SQ    = 16'd50625;
  localparam logic [8:0]  D_BASE      = 9'd225;
  localparam logic [7:0]  K_SAT       = 8'd240;
  localparam logic [7:0]  K_ZERO      = 8'd96;
  localparam logic [7:0]  K_SPAN      = 8'd144;
  localparam logic [7:0]  K_LEN       = 8'd225;
  localparam logic [15:0] MAG_MAX     = 16'hFFFF;
  localparam logic [14:0] UNIT_ONE    = 15'd16384;
  localparam int          FRAC_SH     = 28;
  localparam logic [5:0]  ANG_STEPS   = 6'd44;
  localparam logic [5:0]  DEG_HALF    = 6'd45;
  localparam logic [7:0]  POS_CENTRE  = 8'd127;
  localparam logic [8:0]  POS_FULL    = 9'd255;

  localparam logic [63:0] COS1_Q30 = 64'd1073578288;
  localparam logic [63:0] SIN1_Q30 = 64'd18739379;
  localparam logic [63:0] Q30_HALF = 64'd536870912;

  typedef logic [30:0] adnz_tab_t [45];

  typedef enum logic [3:0] {
    ST_IDLE, ST_CALC, ST_CHK, ST_UDIV, ST_UDIV_W, ST_USQ_W, ST_ANG, ST_MUL1,
    ST_MUL2, ST_CMP, ST_RSQ_W, ST_LHS, ST_MDIV_W, ST_POST, ST_OUT
  } adnz_state_t;

  // one-degree rotations in q30, rounded at each step
  function automatic adnz_tab_t adnz_build_tab(input logic want_sin);
    logic [63:0] c, s, cn, sn;
    adnz_tab_t   t;
    int          k;
    c = 64'd1 << 30;
    s = 64'd0;
    t[0] = want_sin ? s[30:0] : c[30:0];
    for (k = 0; k < 44; k++) begin
      cn = (c * COS1_Q30 - s * SIN1_Q30 + Q30_HALF) >> 30;
      sn = (s * COS1_Q30 + c * SIN1_Q30 + Q30_HALF) >> 30;
      c = cn;
      s = sn;
      t[k + 1] = want_sin ? s[30:0] : c[30:0];
    end
    return t;
  endfunction

  localparam adnz_tab_t COS_TAB = adnz_build_tab(1'b0);
  localparam adnz_tab_t SIN_TAB = adnz_build_tab(1'b1);

endpackage

@@ src/adnz_ifs.sv @@
// request channels of the stick dead zone block
interface adnz_in_if;
  logic       valid;
  logic       ready;
  logic       stick_sel;
  logic       pad_error;
  logic [7:0] left_x;
  logic [7:0] left_y;
  logic [7:0] right_x;
  logic [7:0] right_y;
  logic [3:0] dir_bits;
  logic       fallback_on;
  modport source (output valid, stick_sel, pad_error, left_x, left_y, right_x, right_y,
                  dir_bits, fallback_on, input ready);
  modport sink (input valid, stick_sel, pad_error, left_x, left_y, right_x, right_y,
                dir_bits, fallback_on, output ready);
endinterface

interface adnz_out_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  pos_x;
  logic        [7:0]  pos_y;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_z;
  logic        [15:0] magnitude;
  modport source (output valid, pos_x, pos_y, unit_x, unit_z, magnitude, input ready);
  modport sink (input valid, pos_x, pos_y, unit_x, unit_z, magnitude, output ready);
endinterface

@@ src/adnz_div.sv @@
// restoring divider, one quotient bit per cycle
module adnz_div import adnz_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DVS_W:0]       rem_sh, rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

@@ src/adnz_sqrt.sv @@
// digit-by-digit integer square root, one root bit per cycle
module adnz_sqrt import adnz_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] radicand,
  output logic            done,
  output logic [RT_W-1:0] root
);
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SQ_W-1:0]     rad_r, rad_nxt;
  logic [RT_W:0]       rem_r, rem_nxt;
  logic [RT_W-1:0]     root_r, root_nxt;
  logic [RT_W+2:0]     rem_sh, trial, rem_sub;
  logic                ge;

  assign rem_sh  = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SQ_CNT_W'(RT_W - 1);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[RT_W:0] : rem_sh[RT_W:0];
      root_nxt = {root_r[RT_W-2:0], ge};
      rad_nxt  = {rad_r[SQ_W-3:0], 2'b00};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

@@ src/analog_stick_deadzone_normalize_core.sv @@
// Radial dead zone and normalisation of one analog stick sample per request.
// in_ch carries a pad sample (both sticks, stick select, pad error, direction
// bits, fallback enable); out_ch returns position, Q1.14 direction and a
// 0..65535 magnitude, one result per request, valid/ready on both sides.
// A request is taken only in the idle state; a sequencer then drives a shared
// restoring divider and a shared square-root unit. Path from accept to
// out_ch.valid: a pad error goes straight to the output; a dead-zone sample
// stops after the radius check; a live sample divides and takes a square root
// for each direction component, runs up to 44 angle steps, then at most a
// square root and a divide for the length; a left-stick fallback makes a
// second pass through the above. The result sits in an output register, so a
// new request is taken while out_ch is stalled; the sequencer waits only if it
// finishes again before the old result has gone. Synchronous reset sets the
// last position to 127/127 and the last direction to zero and empties the
// output register.
`include "assert_macros.svh"
module analog_stick_deadzone_normalize_core import adnz_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  adnz_in_if.sink    in_ch,
  adnz_out_if.source out_ch
);
  adnz_state_t state_r, state_nxt;

  logic        sel_r, sel_nxt, err_r, err_nxt, fb_r, fb_nxt, pass_r, pass_nxt;
  logic [3:0]  dirs_r, dirs_nxt;
  logic [7:0]  x_r, x_nxt, y_r, y_nxt;
  logic [16:0] s_r, s_nxt;
  logic        ax_r, ax_nxt, zero_r, zero_nxt;
  logic [15:0] ux_r, ux_nxt, uz_r, uz_nxt, mag_r, mag_nxt;
  logic [5:0]  k_r, k_nxt, d_r, d_nxt;
  logic [32:0] prod_r, prod_nxt, lhs_r, lhs_nxt;
  logic [15:0] t240_r, t240_nxt, t144_r, t144_nxt;
  logic [14:0] t96_r, t96_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [29:0] lo_r, lo_nxt;
  logic [7:0]  last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [15:0] last_ux_r, last_ux_nxt, last_uz_r, last_uz_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [15:0] out_ux_r, out_ux_nxt, out_uz_r, out_uz_nxt, out_mag_r, out_mag_nxt;

  logic             div_start, div_done, sq_start, sq_done;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor;
  logic [SQ_W-1:0]  sq_rad;
  logic [RT_W-1:0]  sq_root;

  logic        in_acc, out_free, ang_pass, u_le_v, do_fb;
  logic [7:0]  p, q, u, v, lo_v, hi_v, fx, fy;
  logic [15:0] pp, qq;
  logic [38:0] ang_lhs, ang_rhs;
  logic [8:0]  dd, fx9, fy9;
  logic [14:0] uabs;
  logic [15:0] usgn;
  logic [30:0] zl;
  logic [32:0] diff;

  adnz_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quo)
  );

  adnz_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // |2x-255| is always odd, so the low bit is fixed
  assign p  = {x_r[7] ? x_r[6:0] : ~x_r[6:0], 1'b1};
  assign q  = {y_r[7] ? y_r[6:0] : ~y_r[6:0], 1'b1};
  assign pp = 16'(p) * 16'(p);
  assign qq = 16'(q) * 16'(q);

  // angle measured from the axis that depends on which half y is in
  assign u      = y_r[7] ? p : q;
  assign v      = y_r[7] ? q : p;
  assign u_le_v = u <= v;
  assign lo_v   = u_le_v ? u : v;
  assign hi_v   = u_le_v ? v : u;
  assign ang_lhs  = 39'(lo_v) * 39'(COS_TAB[k_r]);
  assign ang_rhs  = 39'(hi_v) * 39'(SIN_TAB[k_r]);
  assign ang_pass = ang_lhs >= ang_rhs;

  assign dd   = D_BASE + 9'(d_r);
  assign uabs = (sq_root > RT_W'(UNIT_ONE)) ? UNIT_ONE : sq_root[14:0];
  assign usgn = (ax_r ? !y_r[7] : !x_r[7]) ? 16'(-{1'b0, uabs}) : {1'b0, uabs};
  assign zl   = {t96_r, 16'd0};
  assign diff = lhs_r - 33'(zl);

  // direction-bit fallback from the last position
  assign fx9 = dirs_r[1] ? (9'(last_x_r) + POS_FULL) :
               dirs_r[3] ? 9'(last_x_r) : (9'(last_x_r) + 9'(POS_CENTRE));
  assign fy9 = dirs_r[0] ? 9'(last_y_r) :
               dirs_r[2] ? (9'(last_y_r) + POS_FULL) : (9'(last_y_r) + 9'(POS_CENTRE));
  assign fx  = fx9[8:1];
  assign fy  = fy9[8:1];
  assign do_fb = !pass_r && !sel_r && zero_r && fb_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = in_ch.pad_error ? ST_OUT : ST_CALC;
      ST_CALC:   state_nxt = ST_CHK;
      ST_CHK:    state_nxt = (s_r <= DEAD_S) ? ST_POST : ST_UDIV;
      ST_UDIV:   state_nxt = ST_UDIV_W;
      ST_UDIV_W: if (div_done) state_nxt = ST_USQ_W;
      ST_USQ_W:  if (sq_done) state_nxt = ax_r ? ST_ANG : ST_UDIV;
      ST_ANG:    if (!ang_pass || k_r == ANG_STEPS) state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (prod_r >= 33'(hi_r) || prod_r <= 33'(lo_r)) state_nxt = ST_POST;
        else state_nxt = ST_RSQ_W;
      end
      ST_RSQ_W:  if (sq_done) state_nxt = ST_LHS;
      ST_LHS:    state_nxt = (lhs_r <= 33'(zl)) ? ST_POST : ST_MDIV_W;
      ST_MDIV_W: if (div_done) state_nxt = ST_POST;
      ST_POST:   state_nxt = do_fb ? ST_CALC : ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sel_nxt = sel_r; err_nxt = err_r; fb_nxt = fb_r; dirs_nxt = dirs_r;
    pass_nxt = pass_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; ax_nxt = ax_r;
    zero_nxt = zero_r; ux_nxt = ux_r; uz_nxt = uz_r; mag_nxt = mag_r;
    k_nxt = k_r; d_nxt = d_r; prod_nxt = prod_r; lhs_nxt = lhs_r;
    t240_nxt = t240_r; t144_nxt = t144_r; t96_nxt = t96_r;
    hi_nxt = hi_r; lo_nxt = lo_r;
    last_x_nxt = last_x_r; last_y_nxt = last_y_r;
    last_ux_nxt = last_ux_r; last_uz_nxt = last_uz_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_x_nxt = out_x_r; out_y_nxt = out_y_r; out_ux_nxt = out_ux_r;
    out_uz_nxt = out_uz_r; out_mag_nxt = out_mag_r;
    div_start = 1'b0; div_dividend = '0; div_divisor = '0;
    sq_start = 1'b0; sq_rad = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sel_nxt  = in_ch.stick_sel;
          err_nxt  = in_ch.pad_error;
          fb_nxt   = in_ch.fallback_on;
          dirs_nxt = in_ch.dir_bits;
          x_nxt    = in_ch.stick_sel ? in_ch.right_x : in_ch.left_x;
          y_nxt    = in_ch.stick_sel ? in_ch.right_y : in_ch.left_y;
          pass_nxt = 1'b0;
        end
      end
      ST_CALC: s_nxt = 17'(pp) + 17'(qq);
      ST_CHK: begin
        ax_nxt = 1'b0;
        if (s_r <= DEAD_S) begin
          ux_nxt = '0; uz_nxt = '0; mag_nxt = '0; zero_nxt = 1'b1;
        end
      end
      ST_UDIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({ax_r ? qq : pp, FRAC_SH'(0)});
        div_divisor  = DVS_W'(s_r);
      end
      ST_UDIV_W: begin
        if (div_done) begin
          sq_start = 1'b1;
          sq_rad   = SQ_W'(div_quo);
        end
      end
      ST_USQ_W: begin
        if (sq_done) begin
          if (ax_r) begin
            uz_nxt = usgn;
            k_nxt  = 6'd1;
          end else begin
            ux_nxt = usgn;
            ax_nxt = 1'b1;
          end
        end
      end
      ST_ANG: begin
        if (!ang_pass) begin
          d_nxt = u_le_v ? k_r - 6'd1 : k_r;
        end else if (k_r == ANG_STEPS) begin
          // both legs equal counts as exactly the diagonal
          d_nxt = (u_le_v && u != v) ? ANG_STEPS : DEG_HALF;
        end else begin
          k_nxt = k_r + 6'd1;
        end
      end
      ST_MUL1: begin
        prod_nxt = 33'(s_r) * 33'(SCALE_SQ);
        t240_nxt = 16'(16'(dd) * 16'(K_SAT));
        t96_nxt  = 15'(15'(dd) * 15'(K_ZERO));
        t144_nxt = 16'(16'(dd) * 16'(K_SPAN));
      end
      ST_MUL2: begin
        hi_nxt = 32'(t240_r) * 32'(t240_r);
        lo_nxt = 30'(t96_r) * 30'(t96_r);
      end
      ST_CMP: begin
        if (prod_r >= 33'(hi_r)) begin
          mag_nxt = MAG_MAX; zero_nxt = 1'b0;
        end else if (prod_r <= 33'(lo_r)) begin
          mag_nxt = '0; zero_nxt = 1'b1;
        end else begin
          sq_start = 1'b1;
          sq_rad   = SQ_W'({s_r, 32'd0});
        end
      end
      ST_RSQ_W: if (sq_done) lhs_nxt = 33'(sq_root) * 33'(K_LEN);
      ST_LHS: begin
        zero_nxt = 1'b0;
        if (lhs_r <= 33'(zl)) begin
          mag_nxt = '0;
        end else begin
          div_start    = 1'b1;
          div_dividend = {diff, 16'd0} - DIV_W'(diff);
          div_divisor  = {t144_r, 16'd0};
        end
      end
      ST_MDIV_W: begin
        if (div_done) mag_nxt = (div_quo > DIV_W'(MAG_MAX)) ? MAG_MAX : div_quo[15:0];
      end
      ST_POST: begin
        if (do_fb) begin
          x_nxt = fx; y_nxt = fy; pass_nxt = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt   = err_r ? POS_CENTRE : x_r;
          out_y_nxt   = err_r ? POS_CENTRE : y_r;
          out_ux_nxt  = err_r ? last_ux_r : ux_r;
          out_uz_nxt  = err_r ? last_uz_r : uz_r;
          out_mag_nxt = err_r ? 16'd0 : mag_r;
          last_x_nxt  = err_r ? POS_CENTRE : x_r;
          last_y_nxt  = err_r ? POS_CENTRE : y_r;
          last_ux_nxt = err_r ? last_ux_r : ux_r;
          last_uz_nxt = err_r ? last_uz_r : uz_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_x_r    <= POS_CENTRE;
      last_y_r    <= POS_CENTRE;
      last_ux_r   <= '0;
      last_uz_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_ux_r   <= last_ux_nxt;
      last_uz_r   <= last_uz_nxt;
    end
    sel_r <= sel_nxt; err_r <= err_nxt; fb_r <= fb_nxt; dirs_r <= dirs_nxt;
    pass_r <= pass_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt; ax_r <= ax_nxt;
    zero_r <= zero_nxt; ux_r <= ux_nxt; uz_r <= uz_nxt; mag_r <= mag_nxt;
    k_r <= k_nxt; d_r <= d_nxt; prod_r <= prod_nxt; lhs_r <= lhs_nxt;
    t240_r <= t240_nxt; t144_r <= t144_nxt; t96_r <= t96_nxt;
    hi_r <= hi_nxt; lo_r <= lo_nxt;
    out_x_r <= out_x_nxt; out_y_r <= out_y_nxt; out_ux_r <= out_ux_nxt;
    out_uz_r <= out_uz_nxt; out_mag_r <= out_mag_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pos_x     = out_x_r;
  assign out_ch.pos_y     = out_y_r;
  assign out_ch.unit_x    = out_ux_r;
  assign out_ch.unit_z    = out_uz_r;
  assign out_ch.magnitude = out_mag_r;

  `ADNZ_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_r != ST_IDLE, "request taken but sequencer idle")
  `ADNZ_ASSERT_IMP(a_unit_x_range, out_valid_r, ($signed(out_ux_r) <= $signed({1'b0, UNIT_ONE})) && ($signed(out_ux_r) >= -$signed({1'b0, UNIT_ONE})), "unit_x beyond one")
  `ADNZ_ASSERT_IMP(a_mag_has_dir, out_valid_r && out_mag_r != 16'd0, out_ux_r != 16'd0 || out_uz_r != 16'd0, "magnitude without direction")
endmodule
